@@ rtl/rgbe_pkg.sv @@
package rgbe_pkg;

  // Smallest positive single whose value is not below 1e-32 (sign bit dropped).
  localparam logic [30:0] BLACK_MIN = 31'h0A4F_B11F;
  localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;

  typedef struct packed {
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;
    logic        not_finite;
    logic        black;
    logic [7:0]  top_ex;
  } rgbe_stage_t;

  // Ordering key: a negative channel counts as zero.
  function automatic logic [30:0] chan_key(input logic [31:0] b);
    chan_key = b[31] ? 31'd0 : b[30:0];
  endfunction

  // floor(channel * 2^(8-e)) with e = top_ex - 126; channel <= largest channel.
  function automatic logic [7:0] chan_byte(input logic [31:0] b, input logic [7:0] top_ex);
    logic [7:0]  ex;
    logic [23:0] man;
    logic [9:0]  sh;
    ex  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    man = {(b[30:23] != 8'd0), b[22:0]};
    sh  = 10'd16 + {2'd0, top_ex} - {2'd0, ex};
    if (b[31] || sh >= 10'd32) begin
      chan_byte = 8'd0;
    end else begin
      chan_byte = 8'(man >> sh[4:0]);
    end
  endfunction

endpackage

@@ rtl/rgbe_if.sv @@
interface pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] red_bits;
  logic [31:0] green_bits;
  logic [31:0] blue_bits;
  modport source (output valid, red_bits, green_bits, blue_bits, input ready);
  modport sink (input valid, red_bits, green_bits, blue_bits, output ready);
endinterface

interface rgbe_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_mantissa;
  logic [7:0] green_mantissa;
  logic [7:0] blue_mantissa;
  logic [7:0] shared_exponent;
  logic       not_finite;
  modport source (output valid, red_mantissa, green_mantissa, blue_mantissa,
                  shared_exponent, not_finite, input ready);
  modport sink (input valid, red_mantissa, green_mantissa, blue_mantissa,
                shared_exponent, not_finite, output ready);
endinterface

@@ rtl/rgbe_max.sv @@
module rgbe_max import rgbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] red_bits,
  input  logic [31:0] green_bits,
  input  logic [31:0] blue_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output rgbe_stage_t out_data
);

  logic        v1;
  logic [31:0] r1, g1, b1;
  logic        nf1;
  logic [30:0] rg_key;
  logic        adv1, adv2;
  logic [30:0] top_key;

  assign adv2     = !out_valid || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
    if (adv1 && in_valid) begin
      r1  <= red_bits;
      g1  <= green_bits;
      b1  <= blue_bits;
      nf1 <= (red_bits[30:23] == EXP_ALL_ONES) || (green_bits[30:23] == EXP_ALL_ONES) ||
             (blue_bits[30:23] == EXP_ALL_ONES);
      rg_key <= (chan_key(green_bits) > chan_key(red_bits)) ? chan_key(green_bits)
                                                            : chan_key(red_bits);
    end
  end

  assign top_key = (chan_key(b1) > rg_key) ? chan_key(b1) : rg_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= v1;
    end
    if (adv2 && v1) begin
      out_data.red_bits   <= r1;
      out_data.green_bits <= g1;
      out_data.blue_bits  <= b1;
      out_data.not_finite <= nf1;
      out_data.black      <= top_key < BLACK_MIN;
      out_data.top_ex     <= top_key[30:23];
    end
  end

endmodule

@@ rtl/rgbe_scale.sv @@
module rgbe_scale import rgbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  rgbe_stage_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red_mantissa,
  output logic [7:0]  green_mantissa,
  output logic [7:0]  blue_mantissa,
  output logic [7:0]  shared_exponent,
  output logic        not_finite
);

  logic zero;

  assign in_ready = !out_valid || out_ready;
  assign zero     = in_data.not_finite || in_data.black;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      not_finite      <= in_data.not_finite;
      red_mantissa    <= zero ? 8'd0 : chan_byte(in_data.red_bits, in_data.top_ex);
      green_mantissa  <= zero ? 8'd0 : chan_byte(in_data.green_bits, in_data.top_ex);
      blue_mantissa   <= zero ? 8'd0 : chan_byte(in_data.blue_bits, in_data.top_ex);
      // e + 128 = top_ex + 2, wraps at 256
      shared_exponent <= zero ? 8'd0 : in_data.top_ex + 8'd2;
    end
  end

endmodule

@@ rtl/float_rgb_to_rgbe.sv @@
// Radiance RGBE encoder: takes one pixel of three IEEE single bit patterns per
// cycle and returns three mantissa bytes with a shared exponent byte through
// three register stages (finite check and red/green max, blue max and black
// test, channel shifts). Throughput is one pixel per cycle; each stage holds
// its item while downstream stalls and keeps taking items into empty stages.
// Any NaN or infinity raises not_finite with zero bytes.
module float_rgb_to_rgbe import rgbe_pkg::*; (
  input logic    clk,
  input logic    rst,
  pixel_if.sink  pix_in,
  rgbe_if.source rgbe_out
);

  logic        mid_valid;
  logic        mid_ready;
  rgbe_stage_t mid_data;

  rgbe_max u_max (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pix_in.valid),
    .in_ready   (pix_in.ready),
    .red_bits   (pix_in.red_bits),
    .green_bits (pix_in.green_bits),
    .blue_bits  (pix_in.blue_bits),
    .out_valid  (mid_valid),
    .out_ready  (mid_ready),
    .out_data   (mid_data)
  );

  rgbe_scale u_scale (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (mid_valid),
    .in_ready        (mid_ready),
    .in_data         (mid_data),
    .out_valid       (rgbe_out.valid),
    .out_ready       (rgbe_out.ready),
    .red_mantissa    (rgbe_out.red_mantissa),
    .green_mantissa  (rgbe_out.green_mantissa),
    .blue_mantissa   (rgbe_out.blue_mantissa),
    .shared_exponent (rgbe_out.shared_exponent),
    .not_finite      (rgbe_out.not_finite)
  );

endmodule

@@ rtl/rgbe_checker.sv @@
module rgbe_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_mantissa,
  input logic [7:0] green_mantissa,
  input logic [7:0] blue_mantissa,
  input logic [7:0] shared_exponent,
  input logic       not_finite
);

  // non-finite pixels carry all-zero bytes
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && not_finite |-> red_mantissa == 8'd0 && green_mantissa == 8'd0 &&
      blue_mantissa == 8'd0 && shared_exponent == 8'd0)
    else $error("non-finite item with nonzero bytes");

  // with a nonzero shared exponent, the largest channel lands in [128,255]
  a_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid && shared_exponent != 8'd0 |->
      red_mantissa[7] || green_mantissa[7] || blue_mantissa[7])
    else $error("item not normalized");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(shared_exponent) &&
      $stable(red_mantissa) && $stable(green_mantissa) && $stable(blue_mantissa))
    else $error("stalled item changed");

endmodule

bind float_rgb_to_rgbe rgbe_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (rgbe_out.valid),
  .out_ready       (rgbe_out.ready),
  .red_mantissa    (rgbe_out.red_mantissa),
  .green_mantissa  (rgbe_out.green_mantissa),
  .blue_mantissa   (rgbe_out.blue_mantissa),
  .shared_exponent (rgbe_out.shared_exponent),
  .not_finite      (rgbe_out.not_finite)
);

@@ tb/tb_float_rgb_to_rgbe.sv @@
module tb_float_rgb_to_rgbe;
  import rgbe_pkg::*;

  typedef struct {
    logic [31:0] r, g, b;
  } pixel_t;

  typedef struct {
    logic [7:0] rm, gm, bm, ex;
    logic       nf;
  } rgbe_t;

  // smallest magnitude not below 1e-32
  localparam logic [30:0] DIM_LIMIT = 31'h0A4F_B11F;
  localparam int MAX_CYCLES = 200000;
  localparam int PAUSE_AT = 500;
  localparam int HOLD_AT = 200;
  localparam int HOLD_LEN = 80;
  localparam int QUIET_FROM = 600;
  localparam int QUIET_TO = 850;

  logic clk = 0;
  logic rst = 1;
  int   cycle = 0;
  int   errors = 0;
  int   sent = 0;
  int   hold_left = 0;
  bit   held = 0;

  pixel_t pending_pixels[$];
  rgbe_t  expected_rgbe[$];

  pixel_if pix();
  rgbe_if  enc();

  float_rgb_to_rgbe DUT (.clk(clk), .rst(rst), .pix_in(pix.sink), .rgbe_out(enc.source));

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit special_bits(input logic [31:0] f);
    return f[30:23] == 8'hFF;
  endfunction

  // signed ordering key; +0 and -0 compare equal
  function automatic longint order_key(input logic [31:0] f);
    longint mag;
    mag = longint'(f[30:0]);
    return f[31] ? -mag : mag;
  endfunction

  function automatic logic [7:0] scaled_byte(input logic [31:0] f, input int e);
    int xe, sh;
    logic [23:0] man;
    if (f[31]) return 8'd0;
    xe = (f[30:23] == 0) ? 1 : int'(f[30:23]);
    man = {f[30:23] != 0, f[22:0]};
    sh = 142 + e - xe;
    if (sh < 0) return 8'd255;
    if (sh >= 32) return 8'd0;
    return 8'(man >> sh);
  endfunction

  function automatic rgbe_t encode_pixel(input pixel_t p);
    rgbe_t res;
    logic [31:0] top;
    int e;
    res = '{default: '0};
    if (special_bits(p.r) || special_bits(p.g) || special_bits(p.b)) begin
      res.nf = 1;
      return res;
    end
    top = p.r;
    if (order_key(p.g) > order_key(top)) top = p.g;
    if (order_key(p.b) > order_key(top)) top = p.b;
    if (top[31] || top[30:0] < DIM_LIMIT) return res;
    e = int'(top[30:23]) - 126;
    res.rm = scaled_byte(p.r, e);
    res.gm = scaled_byte(p.g, e);
    res.bm = scaled_byte(p.b, e);
    res.ex = 8'(e + 128);
    return res;
  endfunction

  function automatic logic [31:0] rand_channel(input int base_ex);
    int xe;
    logic [31:0] f;
    f = $urandom;
    xe = base_ex - int'($urandom_range(0, 30));
    if ($urandom_range(0, 9) == 0) xe = $urandom_range(0, 2);
    if (xe < 0) xe = 0;
    if ($urandom_range(0, 99) == 0) xe = 255;
    f[30:23] = 8'(xe);
    f[31] = ($urandom_range(0, 9) == 0);
    return f;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int base;
    if ($urandom_range(0, 9) == 0) begin
      p.r = $urandom; p.g = $urandom; p.b = $urandom;
    end else begin
      base = $urandom_range(0, 6) == 0 ? $urandom_range(250, 254) : $urandom_range(1, 254);
      p.r = rand_channel(base);
      p.g = rand_channel(base);
      p.b = rand_channel(base);
    end
    return p;
  endfunction

  task automatic add_pixel(input logic [31:0] r, g, b);
    pixel_t p;
    p.r = r;
    p.g = g;
    p.b = b;
    pending_pixels.insert(pending_pixels.size(), p);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got, want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle, what, got, want);
    errors++;
  endtask

  function automatic bit quiet_stretch();
    return sent >= QUIET_FROM && sent < QUIET_TO;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 0;
      pix.red_bits <= 0;
      pix.green_bits <= 0;
      pix.blue_bits <= 0;
    end else begin
      if (pix.valid && pix.ready) begin
        expected_rgbe.insert(expected_rgbe.size(), encode_pixel(pending_pixels.pop_front()));
        sent++;
      end
      if (pix.valid && !pix.ready) begin
        // hold the offered item
      end else if (pending_pixels.size() == 0 ||
                   (sent == PAUSE_AT && expected_rgbe.size() != 0) ||
                   (!quiet_stretch() && $urandom_range(0, 99) < 16)) begin
        pix.valid <= 0;
      end else begin
        pix.valid <= 1;
        pix.red_bits <= pending_pixels[0].r;
        pix.green_bits <= pending_pixels[0].g;
        pix.blue_bits <= pending_pixels[0].b;
      end
    end
  end

  // receiver; one long hold-off while the sender keeps offering items
  always @(posedge clk) begin
    if (rst) begin
      enc.ready <= 0;
    end else if (!held && sent >= HOLD_AT) begin
      held <= 1;
      hold_left <= HOLD_LEN;
      enc.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      enc.ready <= 0;
    end else begin
      enc.ready <= quiet_stretch() || $urandom_range(0, 99) >= 16;
    end
  end

  // monitor
  always @(posedge clk) begin
    rgbe_t want;
    if (!rst && enc.valid && enc.ready) begin
      if (expected_rgbe.size() == 0) begin
        $display("unexpected item at cycle %0d", cycle);
        errors++;
      end else begin
        want = expected_rgbe.pop_front();
        if (enc.red_mantissa !== want.rm) report_mismatch("red", enc.red_mantissa, want.rm);
        if (enc.green_mantissa !== want.gm)
          report_mismatch("green", enc.green_mantissa, want.gm);
        if (enc.blue_mantissa !== want.bm) report_mismatch("blue", enc.blue_mantissa, want.bm);
        if (enc.shared_exponent !== want.ex)
          report_mismatch("exponent", enc.shared_exponent, want.ex);
        if (enc.not_finite !== want.nf)
          report_mismatch("not_finite", 8'(enc.not_finite), 8'(want.nf));
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYCLES) begin
      $display("[float_rgb_to_rgbe] ERROR");
      $finish;
    end
  end

  initial begin
    add_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // black
    add_pixel(32'hBF80_0000, 32'hC000_0000, 32'h8000_0000);  // all negative
    add_pixel(32'h3F80_0000, 32'h8000_0000, 32'hBF00_0000);  // negative clamps
    add_pixel(32'h7FC0_0000, 32'h3F80_0000, 32'h3F80_0000);  // NaN red
    add_pixel(32'h3F80_0000, 32'h7F80_0000, 32'h3F80_0000);  // +inf green
    add_pixel(32'h3F80_0000, 32'h3F80_0000, 32'hFF80_0000);  // -inf blue
    add_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_pixel(32'h7F7F_FFFF, 32'h7F00_0000, 32'h0000_0001);  // exponent wrap
    add_pixel(32'h7F00_0000, 32'h0000_0001, 32'h007F_FFFF);  // subnormals vanish
    add_pixel(32'h0A4F_B11F, 32'h0000_0000, 32'h0000_0000);  // at black limit
    add_pixel(32'h0A4F_B11E, 32'h0A4F_B11E, 32'h0A4F_B11E);  // just below
    add_pixel(32'h0080_0000, 32'h007F_FFFF, 32'h0000_0001);
    add_pixel(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    add_pixel(32'h3F7F_FFFF, 32'h3EFF_FFFF, 32'h3E80_0000);
    add_pixel(32'h3F00_0000, 32'h4B7F_FFFF, 32'h3F80_0001);
    add_pixel(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    add_pixel(32'h4000_0000, 32'h4040_0000, 32'h0100_0000);
    for (int i = 0; i < 950; i++) pending_pixels.insert(pending_pixels.size(), rand_pixel());
    repeat (8) @(posedge clk);
    rst <= 0;
    wait (pending_pixels.size() == 0 && expected_rgbe.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_rgbe.size() == 0) begin
      $display("[float_rgb_to_rgbe] OK");
    end else begin
      $display("[float_rgb_to_rgbe] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rgbe_pkg.sv
rtl/rgbe_if.sv
rtl/rgbe_max.sv
rtl/rgbe_scale.sv
rtl/float_rgb_to_rgbe.sv
rtl/rgbe_checker.sv
tb/tb_float_rgb_to_rgbe.sv
